>>> rtl/core/otgr_pkg.sv
package otgr_pkg;

    localparam int GLYPH_BYTES = 12;
    localparam int GLYPH_COUNT = 96;
    localparam int ROM_SIZE    = GLYPH_BYTES * GLYPH_COUNT;
    localparam int ROM_AW      = $clog2(ROM_SIZE);

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] FIRST_CODE = 8'd32;

    localparam logic [7:0] CMD_COLUMN = 8'h21;
    localparam logic [7:0] CMD_PAGE   = 8'h22;
    localparam logic [6:0] COL_STEP   = 7'd7;
    localparam logic [6:0] COL_SPAN   = 7'd5;

    // Beat numbers within the eighteen beats of one character.
    localparam int BEAT_W = 5;
    localparam logic [BEAT_W-1:0] BEAT_COL_CMD    = 5'd0;
    localparam logic [BEAT_W-1:0] BEAT_COL_START  = 5'd1;
    localparam logic [BEAT_W-1:0] BEAT_COL_END    = 5'd2;
    localparam logic [BEAT_W-1:0] BEAT_PAGE_CMD   = 5'd3;
    localparam logic [BEAT_W-1:0] BEAT_PAGE_START = 5'd4;
    localparam logic [BEAT_W-1:0] BEAT_PAGE_END   = 5'd5;
    localparam logic [BEAT_W-1:0] BEAT_DATA_FIRST = 5'd6;
    localparam logic [BEAT_W-1:0] BEAT_LAST       = 5'd17;

    typedef struct packed {
        logic [6:0] column;
        logic       lower_pages;
        logic [6:0] glyph;
    } cmd_t;

endpackage

>>> rtl/core/otgr_front.sv
module otgr_front
    import otgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_code,
    input  logic       start_of_text,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [6:0] column_reg;
    logic [6:0] column_next;
    logic       lower_reg;
    logic       lower_next;
    logic [6:0] col_base;
    logic       lower_base;
    logic       is_break;
    logic       is_print;
    logic [7:0] glyph_full;

    assign col_base   = start_of_text ? 7'd0 : column_reg;
    assign lower_base = start_of_text ? 1'b0 : lower_reg;
    assign is_break   = (char_code == CHAR_LF) || (char_code == CHAR_CR);
    assign is_print   = !char_code[7] && (char_code[6:5] != 2'b00);
    assign glyph_full = char_code - FIRST_CODE;

    assign cmd_push        = accept && is_print;
    assign cmd.column      = col_base;
    assign cmd.lower_pages = lower_base;
    assign cmd.glyph       = glyph_full[6:0];

    always_comb
    begin
        column_next = column_reg;
        lower_next  = lower_reg;
        if (accept)
        begin
            if (is_break)
            begin
                column_next = 7'd0;
                lower_next  = 1'b1;
            end
            else if (is_print)
            begin
                column_next = col_base + COL_STEP;
                lower_next  = lower_base;
            end
            else
            begin
                column_next = col_base;
                lower_next  = lower_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= 7'd0;
            lower_reg  <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            lower_reg  <= lower_next;
        end
    end

endmodule

>>> rtl/core/otgr_cmd_fifo.sv
module otgr_cmd_fifo
    import otgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output cmd_t rd_data
);

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW:0]   count_reg;
    logic [CMDQ_AW:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (count_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/otgr_back.sv
module otgr_back
    import otgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       frame_end,
    output logic       last
);

    localparam logic [7:0] FONT_ROM [ROM_SIZE] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'hfc, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0d, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h1e, 8'h00, 8'h1e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h20, 8'hfc, 8'h20, 8'hfc, 8'h20, 8'h00, 8'h01, 8'h0f, 8'h01, 8'h0f, 8'h01,
        8'h30, 8'h48, 8'h88, 8'hfc, 8'h88, 8'h30, 8'h06, 8'h08, 8'h08, 8'h1f, 8'h08, 8'h07,
        8'h18, 8'h24, 8'ha4, 8'h78, 8'h10, 8'h0c, 8'h0c, 8'h02, 8'h07, 8'h09, 8'h09, 8'h06,
        8'h00, 8'hb8, 8'hc4, 8'h44, 8'h38, 8'h80, 8'h07, 8'h08, 8'h08, 8'h05, 8'h06, 8'h09,
        8'h00, 8'h00, 8'h00, 8'h1e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'he0, 8'h18, 8'h04, 8'h02, 8'h00, 8'h00, 8'h03, 8'h0c, 8'h10, 8'h20,
        8'h00, 8'h02, 8'h04, 8'h18, 8'he0, 8'h00, 8'h00, 8'h20, 8'h10, 8'h0c, 8'h03, 8'h00,
        8'h00, 8'h20, 8'h40, 8'hf0, 8'h40, 8'h20, 8'h00, 8'h02, 8'h01, 8'h07, 8'h01, 8'h02,
        8'h00, 8'h80, 8'h80, 8'hf0, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h24, 8'h1c, 8'h00, 8'h00,
        8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h1c, 8'h08, 8'h00,
        8'h00, 8'h00, 8'h00, 8'he0, 8'h18, 8'h06, 8'h30, 8'h0c, 8'h03, 8'h00, 8'h00, 8'h00,
        8'hf0, 8'h08, 8'h04, 8'h04, 8'h08, 8'hf0, 8'h03, 8'h04, 8'h08, 8'h08, 8'h04, 8'h03,
        8'h00, 8'h10, 8'h08, 8'hfc, 8'h00, 8'h00, 8'h00, 8'h08, 8'h08, 8'h0f, 8'h08, 8'h08,
        8'h18, 8'h04, 8'h04, 8'h04, 8'hc4, 8'h38, 8'h08, 8'h0c, 8'h0a, 8'h09, 8'h08, 8'h08,
        8'h04, 8'h04, 8'h44, 8'h64, 8'h54, 8'h8c, 8'h06, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'h00, 8'hc0, 8'h30, 8'h08, 8'hfc, 8'h00, 8'h03, 8'h02, 8'h02, 8'h02, 8'h0f, 8'h02,
        8'h7c, 8'h24, 8'h24, 8'h24, 8'h24, 8'hc4, 8'h06, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'hf0, 8'h88, 8'h44, 8'h44, 8'h44, 8'h80, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'h04, 8'h04, 8'h04, 8'hc4, 8'h34, 8'h0c, 8'h00, 8'h0c, 8'h03, 8'h00, 8'h00, 8'h00,
        8'h18, 8'ha4, 8'h44, 8'h44, 8'ha4, 8'h18, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'h78, 8'h84, 8'h84, 8'h84, 8'h44, 8'hf8, 8'h06, 8'h08, 8'h08, 8'h08, 8'h04, 8'h03,
        8'h00, 8'h00, 8'h20, 8'h70, 8'h20, 8'h00, 8'h00, 8'h00, 8'h04, 8'h0e, 8'h04, 8'h00,
        8'h00, 8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h0e, 8'h00, 8'h00,
        8'h00, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h00, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
        8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
        8'h00, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h00, 8'h08, 8'h04, 8'h02, 8'h01, 8'h00,
        8'h18, 8'h04, 8'h04, 8'hc4, 8'h24, 8'h18, 8'h00, 8'h00, 8'h00, 8'h0d, 8'h00, 8'h00,
        8'hf0, 8'h08, 8'he4, 8'h14, 8'h14, 8'hf8, 8'h03, 8'h04, 8'h09, 8'h0a, 8'h0a, 8'h0b,
        8'hf0, 8'h88, 8'h84, 8'h84, 8'h88, 8'hf0, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f,
        8'hfc, 8'h44, 8'h44, 8'h44, 8'ha8, 8'h10, 8'h0f, 8'h08, 8'h08, 8'h08, 8'h04, 8'h03,
        8'hf8, 8'h04, 8'h04, 8'h04, 8'h04, 8'h18, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h06,
        8'hfc, 8'h04, 8'h04, 8'h04, 8'h08, 8'hf0, 8'h0f, 8'h08, 8'h08, 8'h08, 8'h04, 8'h03,
        8'hfc, 8'h44, 8'h44, 8'h44, 8'h04, 8'h04, 8'h0f, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
        8'hfc, 8'h44, 8'h44, 8'h44, 8'h04, 8'h04, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hf8, 8'h04, 8'h04, 8'h84, 8'h84, 8'h98, 8'h07, 8'h08, 8'h08, 8'h08, 8'h04, 8'h0f,
        8'hfc, 8'h40, 8'h40, 8'h40, 8'h40, 8'hfc, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f,
        8'h00, 8'h04, 8'h04, 8'hfc, 8'h04, 8'h04, 8'h00, 8'h08, 8'h08, 8'h0f, 8'h08, 8'h08,
        8'h00, 8'h00, 8'h00, 8'h04, 8'hfc, 8'h04, 8'h06, 8'h08, 8'h08, 8'h08, 8'h07, 8'h00,
        8'hfc, 8'h40, 8'ha0, 8'h10, 8'h08, 8'h04, 8'h0f, 8'h00, 8'h00, 8'h01, 8'h02, 8'h0c,
        8'hfc, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
        8'hfc, 8'h18, 8'h60, 8'h60, 8'h18, 8'hfc, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f,
        8'hfc, 8'h30, 8'h40, 8'h80, 8'h00, 8'hfc, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h03, 8'h0f,
        8'hf8, 8'h04, 8'h04, 8'h04, 8'h04, 8'hf8, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'hfc, 8'h84, 8'h84, 8'h84, 8'h84, 8'h78, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hf8, 8'h04, 8'h04, 8'h04, 8'h04, 8'hf8, 8'h07, 8'h09, 8'h09, 8'h0a, 8'h1c, 8'h27,
        8'hfc, 8'h84, 8'h84, 8'h84, 8'h84, 8'h78, 8'h0f, 8'h00, 8'h00, 8'h01, 8'h02, 8'h0c,
        8'h38, 8'h44, 8'h44, 8'h84, 8'h84, 8'h18, 8'h06, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'h04, 8'h04, 8'h04, 8'hfc, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 8'h00,
        8'hfc, 8'h00, 8'h00, 8'h00, 8'h00, 8'hfc, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'h3c, 8'hc0, 8'h00, 8'h00, 8'hc0, 8'h3c, 8'h00, 8'h01, 8'h0e, 8'h0e, 8'h01, 8'h00,
        8'h00, 8'hfc, 8'h00, 8'h00, 8'h00, 8'hfc, 8'h00, 8'h07, 8'h08, 8'h07, 8'h08, 8'h07,
        8'h0c, 8'h30, 8'hc0, 8'hc0, 8'h30, 8'h0c, 8'h0c, 8'h03, 8'h00, 8'h00, 8'h03, 8'h0c,
        8'h00, 8'h1c, 8'h60, 8'h80, 8'h60, 8'h1c, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h00, 8'h00,
        8'h04, 8'h04, 8'h84, 8'h64, 8'h14, 8'h0c, 8'h0c, 8'h0b, 8'h08, 8'h08, 8'h08, 8'h08,
        8'h00, 8'h00, 8'hfe, 8'h02, 8'h02, 8'h02, 8'h00, 8'h00, 8'h3f, 8'h20, 8'h20, 8'h20,
        8'h06, 8'h18, 8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h0c, 8'h30,
        8'h00, 8'h02, 8'h02, 8'h02, 8'hfe, 8'h00, 8'h00, 8'h20, 8'h20, 8'h20, 8'h3f, 8'h00,
        8'h08, 8'h04, 8'h02, 8'h02, 8'h04, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
        8'h00, 8'h00, 8'h02, 8'h04, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h40, 8'h20, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h06, 8'h09, 8'h09, 8'h09, 8'h09, 8'h0f,
        8'hfc, 8'h40, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h0f, 8'h04, 8'h08, 8'h08, 8'h08, 8'h07,
        8'hc0, 8'h20, 8'h20, 8'h20, 8'h20, 8'h40, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h04,
        8'hc0, 8'h20, 8'h20, 8'h20, 8'h40, 8'hfc, 8'h07, 8'h08, 8'h08, 8'h08, 8'h04, 8'h0f,
        8'hc0, 8'h20, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h07, 8'h09, 8'h09, 8'h09, 8'h09, 8'h05,
        8'h40, 8'h40, 8'hf8, 8'h44, 8'h44, 8'h08, 8'h00, 8'h00, 8'h0f, 8'h00, 8'h00, 8'h00,
        8'hc0, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h20, 8'h19, 8'h26, 8'h2a, 8'h2a, 8'h29, 8'h10,
        8'hfc, 8'h40, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f,
        8'h00, 8'h00, 8'h20, 8'hec, 8'h00, 8'h00, 8'h00, 8'h08, 8'h08, 8'h0f, 8'h08, 8'h08,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'hec, 8'h00, 8'h18, 8'h20, 8'h20, 8'h20, 8'h1f,
        8'hfc, 8'h00, 8'h80, 8'h40, 8'h20, 8'h00, 8'h0f, 8'h01, 8'h01, 8'h02, 8'h04, 8'h08,
        8'h00, 8'h00, 8'h04, 8'hfc, 8'h00, 8'h00, 8'h00, 8'h08, 8'h08, 8'h0f, 8'h08, 8'h08,
        8'h00, 8'he0, 8'h20, 8'hc0, 8'h20, 8'hc0, 8'h00, 8'h0f, 8'h00, 8'h07, 8'h00, 8'h0f,
        8'he0, 8'h40, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f,
        8'hc0, 8'h20, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h07, 8'h08, 8'h08, 8'h08, 8'h08, 8'h07,
        8'he0, 8'h40, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h3f, 8'h04, 8'h08, 8'h08, 8'h08, 8'h07,
        8'hc0, 8'h20, 8'h20, 8'h20, 8'h40, 8'he0, 8'h07, 8'h08, 8'h08, 8'h08, 8'h04, 8'h3f,
        8'he0, 8'h40, 8'h20, 8'h20, 8'h20, 8'hc0, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h40, 8'ha0, 8'h20, 8'h20, 8'h20, 8'h40, 8'h04, 8'h08, 8'h09, 8'h09, 8'h0a, 8'h04,
        8'h20, 8'h20, 8'hfc, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00, 8'h07, 8'h08, 8'h08, 8'h04,
        8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 8'he0, 8'h07, 8'h08, 8'h08, 8'h08, 8'h04, 8'h0f,
        8'h00, 8'he0, 8'h00, 8'h00, 8'h00, 8'he0, 8'h00, 8'h00, 8'h03, 8'h0c, 8'h03, 8'h00,
        8'h00, 8'he0, 8'h00, 8'h80, 8'h00, 8'he0, 8'h00, 8'h07, 8'h08, 8'h07, 8'h08, 8'h07,
        8'h60, 8'h80, 8'h00, 8'h00, 8'h80, 8'h60, 8'h0c, 8'h02, 8'h01, 8'h01, 8'h02, 8'h0c,
        8'he0, 8'h00, 8'h00, 8'h00, 8'h00, 8'he0, 8'h13, 8'h24, 8'h24, 8'h24, 8'h22, 8'h1f,
        8'h20, 8'h20, 8'h20, 8'ha0, 8'h60, 8'h20, 8'h08, 8'h0c, 8'h0b, 8'h08, 8'h08, 8'h08,
        8'h00, 8'h00, 8'h80, 8'h7c, 8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h1f, 8'h20, 8'h20,
        8'h00, 8'h00, 8'h00, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3f, 8'h00, 8'h00,
        8'h00, 8'h02, 8'h02, 8'h7c, 8'h80, 8'h00, 8'h00, 8'h20, 8'h20, 8'h1f, 8'h00, 8'h00,
        8'h0c, 8'h02, 8'h04, 8'h08, 8'h10, 8'h0c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hfe, 8'hfe, 8'hfe, 8'hfe, 8'hfe, 8'hfe, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f, 8'h3f
    };

    logic [BEAT_W-1:0] beat_reg;
    logic [BEAT_W-1:0] beat_next;
    logic              advance;
    logic              issue;
    logic              is_data_beat;
    logic [7:0]        cmd_byte;
    logic [ROM_AW-1:0] glyph_ext;
    logic [ROM_AW-1:0] glyph_base;
    logic [BEAT_W-1:0] data_offset;
    logic [ROM_AW-1:0] rom_addr;

    logic              out_valid_reg;
    logic [7:0]        cmd_byte_reg;
    logic [7:0]        rom_q_reg;
    logic              is_data_reg;
    logic              frame_end_reg;
    logic              last_reg;

    // The output register takes a new beat when it is empty or being drained.
    assign advance      = !out_valid_reg || pop;
    assign issue        = advance && cmd_valid;
    assign cmd_pop      = issue && (beat_reg == BEAT_LAST);
    assign is_data_beat = (beat_reg >= BEAT_DATA_FIRST);

    assign glyph_ext   = ROM_AW'(cmd.glyph);
    assign glyph_base  = (glyph_ext << 3) + (glyph_ext << 2);
    assign data_offset = beat_reg - BEAT_DATA_FIRST;
    assign rom_addr    = glyph_base + ROM_AW'(data_offset);

    always_comb
    begin
        case (beat_reg)
            BEAT_COL_CMD:    cmd_byte = CMD_COLUMN;
            BEAT_COL_START:  cmd_byte = {1'b0, cmd.column};
            BEAT_COL_END:    cmd_byte = {1'b0, cmd.column + COL_SPAN};
            BEAT_PAGE_CMD:   cmd_byte = CMD_PAGE;
            BEAT_PAGE_START: cmd_byte = {6'd0, cmd.lower_pages, 1'b0};
            BEAT_PAGE_END:   cmd_byte = {6'd0, cmd.lower_pages, 1'b1};
            default:         cmd_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        beat_next = beat_reg;
        if (issue)
        begin
            beat_next = (beat_reg == BEAT_LAST) ? '0 : beat_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg <= beat_next;
            if (advance)
            begin
                out_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmd_byte_reg  <= cmd_byte;
            rom_q_reg     <= FONT_ROM[rom_addr];
            is_data_reg   <= is_data_beat;
            frame_end_reg <= (beat_reg == BEAT_COL_END) || (beat_reg == BEAT_PAGE_END)
                             || (beat_reg == BEAT_LAST);
            last_reg      <= (beat_reg == BEAT_LAST);
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = is_data_reg ? rom_q_reg : cmd_byte_reg;
    assign is_data   = is_data_reg;
    assign frame_end = frame_end_reg;
    assign last      = last_reg;

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg <= BEAT_LAST)
        else $error("beat counter ran past the last beat");

    a_beat_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (beat_reg == BEAT_COL_CMD))
        else $error("beat counter did not restart after a character");

    a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command queue popped while empty");

    a_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (is_data_reg && frame_end_reg))
        else $error("final beat lacks data or frame end marking");

    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && (beat_reg != BEAT_COL_CMD)) |-> $stable(cmd))
        else $error("command changed in the middle of a character");

endmodule

>>> rtl/core/oled_text_glyph_renderer_unit.sv
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ------------------------------------------
// input     in         push / full          char_code[7:0], start_of_text
// result    out        empty / pop          out_byte[7:0], is_data, frame_end, last
//
// A printable character yields eighteen result beats at up to one beat per cycle while pop is
// high and the queue holds a command; the back end's beat counter sets that figure. Line breaks
// and dropped codes are accepted like any character but produce no beat.
// The front end accepts until the queue holds two characters, the one in progress and one more.
// The output register holds a beat while pop is low; the queue absorbs stalls meanwhile.
// Reset clears the column, the page pair, the queue, the beat counter and the output valid flag.
module oled_text_glyph_renderer_unit
    import otgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       start_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       frame_end,
    output logic       last
);

    // Every accepted character passes through the front end, which tracks the cursor
    // and turns printable codes into one queued command each.
    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd_out;

    assign accept = push && !full;

    otgr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_code     (char_code),
        .start_of_text (start_of_text),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in)
    );

    // The queue is full-gated at the input, so a line break also waits for space; this
    // keeps the cursor update and the command push in the same cycle.
    otgr_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .full     (full),
        .rd_en    (cmd_pop),
        .rd_valid (cmd_valid),
        .rd_data  (cmd_out)
    );

    // The back end walks the six command beats and twelve font beats of the head
    // command, then releases it from the queue.
    otgr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .is_data   (is_data),
        .frame_end (frame_end),
        .last      (last)
    );

endmodule

>>> tb/tb_oled_text_glyph_renderer_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the text glyph renderer.
//
// Character beats go in through the push/full side and display bytes come back through the
// empty/pop side. Every character that the block accepts is run through a local model of
// the cursor (column and page pair) and of the font table. Each display byte that the model
// predicts is queued, and the checker compares every popped beat with the oldest entry.
//
// The stimulus starts with a short directed pass over the corner cases. Random text follows
// in three phases that change which side idles. A final phase stalls the receiver for a long
// stretch so that the block fills up and pushes back on the sender.
module tb_oled_text_glyph_renderer_unit;
    import otgr_pkg::*;

    localparam logic [7:0] LAST_CODE   = 8'h7f;
    localparam int         MAX_REPORTS = 10;
    localparam int         STALL_LONG  = 400;
    localparam int         DRAIN_TAIL  = 40;

    // One byte on its way to the display, with its three side-band flags.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
        logic       last;
    } display_beat_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic [7:0] char_code     = 8'd0;
    logic       start_of_text = 1'b0;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
    logic       last;

    // Cursor state of the local model.
    logic [6:0] cursor_col   = '0;
    logic       cursor_lower = 1'b0;

    // Display bytes that the model has predicted and the block has not yet delivered.
    display_beat_t display_fifo[$];

    // Idle rates in percent per cycle for each side, and the receiver hold-off counter.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;

    int mismatches    = 0;
    int beats_checked = 0;
    int chars_sent    = 0;
    int breaks_sent   = 0;
    int codes_dropped = 0;

    oled_text_glyph_renderer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .start_of_text(start_of_text),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .is_data      (is_data),
        .frame_end    (frame_end),
        .last         (last)
    );

    always #2 clk = ~clk;

    // Font table, one glyph per row. The first of the twelve bytes sits in the top byte.
    // The first six bytes are the upper page of the glyph and the last six the lower page.
    function automatic logic [95:0] glyph_row(input int glyph);
        case (glyph)
            0:  return 96'h000000000000_000000000000;
            1:  return 96'h000000fc0000_0000000d0000;
            2:  return 96'h00001e001e00_000000000000;
            3:  return 96'h0020fc20fc20_00010f010f01;
            4:  return 96'h304888fc8830_0608081f0807;
            5:  return 96'h1824a478100c_0c0207090906;
            6:  return 96'h00b8c4443880_070808050609;
            7:  return 96'h0000001e0000_000000000000;
            8:  return 96'h0000e0180402_0000030c1020;
            9:  return 96'h00020418e000_0020100c0300;
            10: return 96'h002040f04020_000201070102;
            11: return 96'h008080f08080_000000070000;
            12: return 96'h000000000000_0000241c0000;
            13: return 96'h008080808080_000000000000;
            14: return 96'h000000000000_0000081c0800;
            15: return 96'h000000e01806_300c03000000;
            16: return 96'hf008040408f0_030408080403;
            17: return 96'h001008fc0000_0008080f0808;
            18: return 96'h18040404c438_080c0a090808;
            19: return 96'h04044464548c_060808080807;
            20: return 96'h00c03008fc00_030202020f02;
            21: return 96'h7c24242424c4_060808080807;
            22: return 96'hf08844444480_070808080807;
            23: return 96'h040404c4340c_000c03000000;
            24: return 96'h18a44444a418_070808080807;
            25: return 96'h7884848444f8_060808080403;
            26: return 96'h000020702000_0000040e0400;
            27: return 96'h000060600000_0000120e0000;
            28: return 96'h008040201008_000001020408;
            29: return 96'h202020202020_010101010101;
            30: return 96'h000810204080_000804020100;
            31: return 96'h180404c42418_0000000d0000;
            32: return 96'hf008e41414f8_0304090a0a0b;
            33: return 96'hf088848488f0_0f000000000f;
            34: return 96'hfc444444a810_0f0808080403;
            35: return 96'hf80404040418_070808080806;
            36: return 96'hfc04040408f0_0f0808080403;
            37: return 96'hfc4444440404_0f0808080808;
            38: return 96'hfc4444440404_0f0000000000;
            39: return 96'hf80404848498_07080808040f;
            40: return 96'hfc40404040fc_0f000000000f;
            41: return 96'h000404fc0404_0008080f0808;
            42: return 96'h00000004fc04_060808080700;
            43: return 96'hfc40a0100804_0f000001020c;
            44: return 96'hfc0000000000_0f0808080808;
            45: return 96'hfc18606018fc_0f000000000f;
            46: return 96'hfc30408000fc_0f000000030f;
            47: return 96'hf804040404f8_070808080807;
            48: return 96'hfc8484848478_0f0000000000;
            49: return 96'hf804040404f8_0709090a1c27;
            50: return 96'hfc8484848478_0f000001020c;
            51: return 96'h384444848418_060808080807;
            52: return 96'h040404fc0404_0000000f0000;
            53: return 96'hfc00000000fc_070808080807;
            54: return 96'h3cc00000c03c_00010e0e0100;
            55: return 96'h00fc000000fc_000708070807;
            56: return 96'h0c30c0c0300c_0c030000030c;
            57: return 96'h001c6080601c_0000000f0000;
            58: return 96'h04048464140c_0c0b08080808;
            59: return 96'h0000fe020202_00003f202020;
            60: return 96'h0618e0000000_000000030c30;
            61: return 96'h00020202fe00_002020203f00;
            62: return 96'h080402020408_000000000000;
            63: return 96'h000000000000_202020202020;
            64: return 96'h000002040800_000000000000;
            65: return 96'h4020202020c0_06090909090f;
            66: return 96'hfc40202020c0_0f0408080807;
            67: return 96'hc02020202040_070808080804;
            68: return 96'hc020202040fc_07080808040f;
            69: return 96'hc020202020c0_070909090905;
            70: return 96'h4040f8444408_00000f000000;
            71: return 96'hc0202020c020_19262a2a2910;
            72: return 96'hfc40202020c0_0f000000000f;
            73: return 96'h000020ec0000_0008080f0808;
            74: return 96'h0000000020ec_00182020201f;
            75: return 96'hfc0080402000_0f0101020408;
            76: return 96'h000004fc0000_0008080f0808;
            77: return 96'h00e020c020c0_000f0007000f;
            78: return 96'he040202020c0_0f000000000f;
            79: return 96'hc020202020c0_070808080807;
            80: return 96'he040202020c0_3f0408080807;
            81: return 96'hc020202040e0_07080808043f;
            82: return 96'he040202020c0_0f0000000000;
            83: return 96'h40a020202040_040809090a04;
            84: return 96'h2020fc202000_000007080804;
            85: return 96'he000000000e0_07080808040f;
            86: return 96'h00e0000000e0_0000030c0300;
            87: return 96'h00e0008000e0_000708070807;
            88: return 96'h608000008060_0c020101020c;
            89: return 96'he000000000e0_13242424221f;
            90: return 96'h202020a06020_080c0b080808;
            91: return 96'h0000807c0202_0000001f2020;
            92: return 96'h000000fe0000_0000003f0000;
            93: return 96'h0002027c8000_0020201f0000;
            94: return 96'h0c020408100c_000000000000;
            95: return 96'hfefefefefefe_3f3f3f3f3f3f;
            default: return '0;
        endcase
    endfunction

    function automatic void queue_beat(input logic [7:0] b, input logic data,
                                       input logic fend, input logic fin);
        display_beat_t beat;
        beat.out_byte  = b;
        beat.is_data   = data;
        beat.frame_end = fend;
        beat.last      = fin;
        display_fifo.push_back(beat);
    endfunction

    // Updates the cursor for one accepted character and queues the bytes that it should
    // produce: the column window, the page window, then the twelve glyph bytes.
    function automatic void render_char(input logic [7:0] code, input logic sot);
        logic [6:0]  col_end;
        logic [1:0]  page_first;
        logic [95:0] row;
        if (sot)
        begin
            cursor_col   = '0;
            cursor_lower = 1'b0;
        end
        if (code == CHAR_LF || code == CHAR_CR)
        begin
            // A line break moves to the lower page pair and back to the left edge.
            cursor_lower = 1'b1;
            cursor_col   = '0;
            breaks_sent++;
            return;
        end
        if (code < FIRST_CODE || code > LAST_CODE)
        begin
            // Control codes and the upper half of the byte range have no glyph.
            codes_dropped++;
            return;
        end
        col_end    = cursor_col + COL_SPAN;
        page_first = cursor_lower ? 2'd2 : 2'd0;
        queue_beat(CMD_COLUMN, 1'b0, 1'b0, 1'b0);
        queue_beat({1'b0, cursor_col}, 1'b0, 1'b0, 1'b0);
        queue_beat({1'b0, col_end}, 1'b0, 1'b1, 1'b0);
        queue_beat(CMD_PAGE, 1'b0, 1'b0, 1'b0);
        queue_beat({6'd0, page_first}, 1'b0, 1'b0, 1'b0);
        queue_beat({6'd0, page_first + 2'd1}, 1'b0, 1'b1, 1'b0);
        row = glyph_row(int'(code - FIRST_CODE));
        for (int i = 0; i < GLYPH_BYTES; i++)
        begin
            queue_beat(row[95 - 8 * i -: 8], 1'b1, i == GLYPH_BYTES - 1,
                       i == GLYPH_BYTES - 1);
        end
        // The column wraps modulo 128, so a long line starts over at the left.
        cursor_col = cursor_col + COL_STEP;
        chars_sent++;
    endfunction

    // Offers one character and returns once the block has taken it. A random number of idle
    // cycles may come first. Push stays high between back-to-back beats, so it is never
    // lowered and raised in the same time step.
    task automatic send_char(input logic [7:0] code, input logic sot);
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        char_code     <= code;
        start_of_text <= sot;
        @(posedge clk);
        while (full) @(posedge clk);
        render_char(code, sot);
    endtask

    // Mostly printable text in long runs, so that the column wraps. Line breaks and
    // start-of-text marks are mixed in, along with a little noise from codes without a glyph.
    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 86)
            return FIRST_CODE + 8'($urandom_range(95));
        else if (r < 89)
            return CHAR_LF;
        else if (r < 91)
            return CHAR_CR;
        else if (r < 96)
            return 8'($urandom_range(255, 128));
        else
            return 8'($urandom_range(31));
    endfunction

    // Corner cases: both ends of the printable range, the codes either side of it, the top
    // of the byte range, both line breaks, and start-of-text on a dropped code and on a
    // line break.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_char(FIRST_CODE, 1'b1);
        send_char(LAST_CODE, 1'b0);
        send_char("A", 1'b0);
        send_char(8'd0, 1'b0);
        send_char(8'd255, 1'b0);
        // A dropped code still applies its start-of-text reset.
        send_char(8'd128, 1'b1);
        send_char("B", 1'b0);
        send_char(CHAR_LF, 1'b0);
        send_char("C", 1'b0);
        send_char(8'd31, 1'b0);
        send_char("D", 1'b0);
        send_char(CHAR_CR, 1'b0);
        send_char("E", 1'b0);
        // The reset comes first and the line break after it, so the lower pair wins.
        send_char(CHAR_LF, 1'b1);
        send_char("F", 1'b0);
        send_char("G", 1'b1);
        send_char(8'd9, 1'b0);
        send_char(8'd11, 1'b0);
        send_char(8'd12, 1'b0);
        send_char(8'd14, 1'b0);
        send_char(LAST_CODE, 1'b0);
        send_char("0", 1'b0);
    endtask

    // Random text until the given number of characters and line breaks has gone in.
    // Dropped codes do not count toward that number.
    task automatic test_random_text(input int n_items, input int send_pct, input int recv_pct);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = chars_sent + breaks_sent + n_items;
        while (chars_sent + breaks_sent < target)
            send_char(pick_code(), $urandom_range(39) == 0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering printable
    // characters back to back, so that the queue fills and full pushes back.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left   <= STALL_LONG;
        for (int i = 0; i < 12; i++)
            send_char(FIRST_CODE + 8'($urandom_range(95)), 1'b0);
    endtask

    // Hold-off counter for the receiver; it counts down one per cycle.
    always @(posedge clk)
        if (stall_left > 0)
            stall_left <= stall_left - 1;

    // The receiver pops at random, except during a hold-off.
    always @(posedge clk)
        pop <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);

    // Every beat that is popped is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_beats
        display_beat_t want;
        if (rst_n && pop && !empty)
        begin
            beats_checked++;
            if (display_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: byte %02h data %b frame_end %b last %b",
                             out_byte, is_data, frame_end, last);
            end
            else
            begin
                want = display_fifo.pop_front();
                if (out_byte !== want.out_byte || is_data !== want.is_data ||
                    frame_end !== want.frame_end || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("beat %0d: expected %02h %b %b %b, got %02h %b %b %b",
                                 beats_checked, want.out_byte, want.is_data, want.frame_end,
                                 want.last, out_byte, is_data, frame_end, last);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(70, 14, 68);
        test_random_text(70, 68, 14);
        test_random_text(55, 0, 0);
        test_backpressure();

        // Let the receiver drain everything, then give the block time to show any stray beat.
        push          <= 1'b0;
        recv_idle_pct  = 0;
        while (display_fifo.size() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Covered %0d glyphs, %0d line breaks and %0d dropped codes.",
                 chars_sent, breaks_sent, codes_dropped);
        $display("Checked %0d display beats under both idle mixes and a full-queue stall.",
                 beats_checked);
        if (mismatches == 0 && display_fifo.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/otgr_pkg.sv
rtl/core/otgr_front.sv
rtl/core/otgr_cmd_fifo.sv
rtl/core/otgr_back.sv
rtl/core/oled_text_glyph_renderer_unit.sv
tb/tb_oled_text_glyph_renderer_unit.sv
